// ===== sv/b64sd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64sd_pkg
// Types, codes and the alphabet lookup shared by the strict base64 decoder.
// ----------------------------------------------------------------------------
package b64sd_pkg;

  localparam int FIFO_DEPTH = 8;  // result queue entries, at least 4
  localparam int RES_MAX    = 3;  // results one character can cause

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  typedef logic [2:0] err_t;
  localparam err_t ERR_NONE          = 3'd0;
  localparam err_t ERR_LENGTH        = 3'd1;
  localparam err_t ERR_BAD_PAD       = 3'd2;
  localparam err_t ERR_PAD_NOT_FINAL = 3'd3;
  localparam err_t ERR_INVALID_CHAR  = 3'd4;
  localparam err_t ERR_PAD_BITS      = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    err_t       error_code;
    logic       end_flag;
  } res_t;

  // Results of one accepted character, in delivery order.
  typedef struct packed {
    logic [1:0]           count;
    res_t [RES_MAX-1:0]   item;
  } push_t;

  typedef struct packed {
    logic       valid;
    logic [5:0] value;
  } sextet_t;

  // Standard alphabet: A-Z, a-z, 0-9, '+', '/'.
  function automatic sextet_t sextet_of(input logic [7:0] c);
    sextet_t r;
    r.valid = 1'b1;
    r.value = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r.value = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r.value = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.value = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      r.value = 6'd62;
    end else if (c == 8'h2F) begin
      r.value = 6'd63;
    end else begin
      r.valid = 1'b0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/b64sd_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64sd_decode
// Group state and strict checks; turns each accepted character into zero to
// three results.
// ----------------------------------------------------------------------------
module b64sd_decode (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             take,
  input  wire logic [7:0]       char_code,
  input  wire logic             last_char,
  output b64sd_pkg::push_t      push
);
  import b64sd_pkg::*;

  logic [1:0]  group_position,     group_position_next;
  logic [17:0] sextet_accumulator, sextet_accumulator_next;
  logic        third_is_pad,       third_is_pad_next;
  logic        bad_char_seen,      bad_char_seen_next;
  logic        failed,             failed_next;

  sextet_t     sx;
  logic [5:0]  v;
  logic        pad2, pad3;
  logic [23:0] value;
  err_t        err;
  push_t       res;

  always_comb begin
    sx    = sextet_of(char_code);
    v     = sx.value;
    pad2  = third_is_pad;
    pad3  = (char_code == PAD_CHAR);
    value = {sextet_accumulator, pad3 ? 6'd0 : sx.value};
    err   = ERR_NONE;

    group_position_next     = group_position;
    sextet_accumulator_next = sextet_accumulator;
    third_is_pad_next       = third_is_pad;
    bad_char_seen_next      = bad_char_seen;
    failed_next             = failed;

    res       = '0;
    res.count = 2'd0;

    if (failed) begin
      // drop everything up to the last character of the text
      if (last_char) begin
        failed_next = 1'b0;
      end
    end else if (group_position != 2'd3) begin
      if (last_char) begin
        res.count   = 2'd1;
        res.item[0] = '{data_byte: 8'd0, error_code: ERR_LENGTH, end_flag: 1'b1};
        group_position_next     = 2'd0;
        sextet_accumulator_next = '0;
        third_is_pad_next       = 1'b0;
        bad_char_seen_next      = 1'b0;
      end else begin
        if (group_position == 2'd2 && pad3) begin
          third_is_pad_next = 1'b1;
          v = 6'd0;
        end else if (!sx.valid) begin
          bad_char_seen_next = 1'b1;
          v = 6'd0;
        end
        sextet_accumulator_next = {sextet_accumulator[11:0], v};
        group_position_next     = group_position + 2'd1;
      end
    end else begin
      if (pad2 && !pad3) begin
        err = ERR_BAD_PAD;
      end else if ((pad2 || pad3) && !last_char) begin
        err = ERR_PAD_NOT_FINAL;
      end else if (bad_char_seen || (!pad3 && !sx.valid)) begin
        err = ERR_INVALID_CHAR;
      end else if ((pad2 && value[15:0] != 16'd0) ||
                   (pad3 && !pad2 && value[7:0] != 8'd0)) begin
        err = ERR_PAD_BITS;
      end

      group_position_next     = 2'd0;
      sextet_accumulator_next = '0;
      third_is_pad_next       = 1'b0;
      bad_char_seen_next      = 1'b0;

      if (err != ERR_NONE) begin
        res.count   = 2'd1;
        res.item[0] = '{data_byte: 8'd0, error_code: err, end_flag: 1'b1};
        failed_next = !last_char;
      end else begin
        res.count = pad2 ? 2'd1 : (pad3 ? 2'd2 : 2'd3);
        res.item[0] = '{data_byte: value[23:16], error_code: ERR_NONE,
                        end_flag: pad2 && last_char};
        res.item[1] = '{data_byte: value[15:8], error_code: ERR_NONE,
                        end_flag: !pad2 && pad3 && last_char};
        res.item[2] = '{data_byte: value[7:0], error_code: ERR_NONE,
                        end_flag: last_char};
      end
    end

    push = res;
    if (!take) begin
      push.count = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_position     <= 2'd0;
      sextet_accumulator <= '0;
      third_is_pad       <= 1'b0;
      bad_char_seen      <= 1'b0;
      failed             <= 1'b0;
    end else if (take) begin
      group_position     <= group_position_next;
      sextet_accumulator <= sextet_accumulator_next;
      third_is_pad       <= third_is_pad_next;
      bad_char_seen      <= bad_char_seen_next;
      failed             <= failed_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/b64sd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64sd_queue
// Result queue: takes up to three results per cycle, hands out one per beat.
// ----------------------------------------------------------------------------
module b64sd_queue #(
  parameter int DEPTH = b64sd_pkg::FIFO_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire b64sd_pkg::push_t push,
  output logic                  room,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output b64sd_pkg::res_t       out_item
);
  import b64sd_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  res_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count, count_next;
  logic          pop;

  function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] p,
                                             input logic [1:0] k);
    logic [PW:0] s;
    s = {1'b0, p} + (PW+1)'(k);
    if (s >= (PW+1)'(DEPTH)) begin
      s = s - (PW+1)'(DEPTH);
    end
    return s[PW-1:0];
  endfunction

  assign out_valid = (count != '0);
  assign out_item  = mem[rd_ptr];
  assign pop       = out_valid && out_ready;
  // Accept only with space for the largest burst one character can cause.
  assign room      = (count <= CW'(DEPTH - RES_MAX));

  always_comb begin
    count_next = count + CW'(push.count) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < RES_MAX; k++) begin
      if (2'(k) < push.count) begin
        mem[wrap_add(wr_ptr, 2'(k))] <= push.item[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wrap_add(wr_ptr, push.count);
      rd_ptr <= wrap_add(rd_ptr, {1'b0, pop});
      count  <= count_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/base64_strict_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// base64_strict_decoder
// Strict streaming base64 decoder: one character per beat in, decoded bytes
// or a single error result out.
// ----------------------------------------------------------------------------
//
//   channel  dir  tdata            tuser       tlast
//   s_*      in   char_code[7:0]   -           last_char
//   m_*      out  data_byte[7:0]   error_code  end_flag
//
// One character is accepted per cycle while s_tready is high. Its group logic
// settles in the same cycle and writes zero to three results into an
// eight-entry result queue; the first result can leave on the next cycle.
// s_tready drops only while the queue could not take a full three-result
// burst, so with m_tready held high the input never stalls (three bytes out
// per four characters). Reset (rst, synchronous) clears the group state, the
// error flag and the queue pointers. Stalling m_tready holds the head result
// steady.
module base64_strict_decoder #(
  parameter int FIFO_DEPTH = b64sd_pkg::FIFO_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  // input characters
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] char_code
  input  wire logic       s_tlast,   // last_char
  // decoded results
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] data_byte
  output logic [2:0]      m_tuser,   // [2:0] error_code
  output logic            m_tlast    // end_flag
);
  import b64sd_pkg::*;

  push_t push;
  res_t  head;
  logic  room;
  logic  take;

  // A beat moves when the queue has room for the worst-case burst.
  assign s_tready = room;
  assign take     = s_tvalid && room;

  b64sd_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .char_code (s_tdata),
    .last_char (s_tlast),
    .push      (push)
  );

  b64sd_queue #(
    .DEPTH (FIFO_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_item  (head)
  );

  // Present the queue head on the master side.
  assign m_tdata = head.data_byte;
  assign m_tuser = head.error_code;
  assign m_tlast = head.end_flag;

endmodule
`default_nettype wire
